@@ sv/qvr_pkg.sv @@
// qvr_pkg: widths shared by the quaternion vector rotation pipeline.
// Depends on nothing.
package qvr_pkg;

    // quaternion component width, signed Q2.14
    localparam int QUAT_W = 16;
    // squared norm of a quaternion: sum of four squares, unsigned
    localparam int NORM_W = 2 * QUAT_W + 1;
    // w^2 - u.u, signed
    localparam int A_W    = 2 * QUAT_W + 1;
    // divider remainder, never above the norm unless the quotient saturates
    localparam int REM_W  = NORM_W;
    // number of vector lanes
    localparam int LANES  = 3;

endpackage

@@ sv/quaternion_vector_rotate.sv @@
// quaternion_vector_rotate: rotates a Q16.16 vector by a Q2.14 quaternion, q*(0,v)*q^-1.
// Uses qvr_pkg. Fully pipelined: multiply stages, then a one-bit-per-stage divider.
//
// channel | ports                                        | dir | handshake
// --------+----------------------------------------------+-----+-----------------
// s_      | s_quat_w/x/y/z, s_vec_x/y/z                  | in  | s_valid/s_ready
// m_      | m_rot_x/y/z, m_zero_norm, m_saturated        | out | m_valid/m_ready
//
// An accepted word passes stages 1 to 5, the divider stages and the output register on
// its way to its result word; one word per cycle enters when the output is taken. The
// depth comes from the restoring divider, one quotient bit per stage for all three lanes.
// Reset (aresetn low, synchronous) clears every stage valid bit.
// A stall halts only stages that are full and blocked; empty stages keep filling.
module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [QUAT_W-1:0]    s_quat_w,
    input  logic signed [QUAT_W-1:0]    s_quat_x,
    input  logic signed [QUAT_W-1:0]    s_quat_y,
    input  logic signed [QUAT_W-1:0]    s_quat_z,
    input  logic signed [VEC_WIDTH-1:0] s_vec_x,
    input  logic signed [VEC_WIDTH-1:0] s_vec_y,
    input  logic signed [VEC_WIDTH-1:0] s_vec_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [VEC_WIDTH-1:0] m_rot_x,
    output logic signed [VEC_WIDTH-1:0] m_rot_y,
    output logic signed [VEC_WIDTH-1:0] m_rot_z,
    output logic                        m_zero_norm,
    output logic                        m_saturated
);

    localparam int VW   = VEC_WIDTH;
    localparam int SQ_W = 2 * QUAT_W;
    localparam int VU_W = VW + QUAT_W;
    localparam int D_W  = VW + QUAT_W + 2;
    localparam int PA_W = VW + A_W;
    localparam int PD_W = D_W + QUAT_W + 1;
    localparam int NW   = PD_W + 2;
    localparam int HW   = NW - VW;

    // ---------------- stage 1: all squares and v*u products ----------------
    logic                     e1, e2, e3, e4, e5;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [SQ_W-1:0]   sqw_reg, squ_reg [LANES];
    logic signed [VU_W-1:0]   vu_reg [LANES][LANES];
    logic signed [QUAT_W-1:0] w1_reg, u1_reg [LANES];
    logic signed [VW-1:0]     vv1_reg [LANES];
    logic signed [QUAT_W-1:0] in_u [LANES];
    logic signed [VW-1:0]     in_v [LANES];

    assign in_u[0] = s_quat_x;
    assign in_u[1] = s_quat_y;
    assign in_u[2] = s_quat_z;
    assign in_v[0] = s_vec_x;
    assign in_v[1] = s_vec_y;
    assign in_v[2] = s_vec_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (e1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (e1) begin
            sqw_reg <= s_quat_w * s_quat_w;
            w1_reg  <= s_quat_w;
            for (int i = 0; i < LANES; i++) begin
                squ_reg[i] <= in_u[i] * in_u[i];
                u1_reg[i]  <= in_u[i];
                vv1_reg[i] <= in_v[i];
                for (int j = 0; j < LANES; j++) begin
                    vu_reg[i][j] <= in_v[i] * in_u[j];
                end
            end
        end
    end

    // ---------------- stage 2: norm, w^2-u.u, dot and cross ----------------
    logic [NORM_W-1:0]        n2_reg;
    logic signed [A_W-1:0]    a2_reg;
    logic signed [D_W-1:0]    d2_reg, c2_reg [LANES];
    logic signed [QUAT_W-1:0] w2_reg, u2_reg [LANES];
    logic signed [VW-1:0]     vv2_reg [LANES];
    logic [NORM_W-1:0]        uu_sum;

    assign uu_sum = NORM_W'(squ_reg[0]) + NORM_W'(squ_reg[1]) + NORM_W'(squ_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (e2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e2) begin
            n2_reg <= NORM_W'(sqw_reg) + uu_sum;
            a2_reg <= $signed(A_W'(sqw_reg)) - $signed(uu_sum);
            d2_reg <= D_W'(vu_reg[0][0]) + D_W'(vu_reg[1][1]) + D_W'(vu_reg[2][2]);
            w2_reg <= w1_reg;
            for (int i = 0; i < LANES; i++) begin
                // (u x v)_i = u_j1 v_j2 - u_j2 v_j1
                c2_reg[i] <= D_W'(vu_reg[(i + 2) % LANES][(i + 1) % LANES])
                           - D_W'(vu_reg[(i + 1) % LANES][(i + 2) % LANES]);
                u2_reg[i]  <= u1_reg[i];
                vv2_reg[i] <= vv1_reg[i];
            end
        end
    end

    // ---------------- stage 3: the three numerator terms per lane ----------------
    logic signed [PA_W-1:0]   pa3_reg [LANES];
    logic signed [PD_W-1:0]   pd3_reg [LANES], pc3_reg [LANES];
    logic [NORM_W-1:0]        n3_reg;
    logic signed [QUAT_W:0]   two_w, two_u [LANES];

    always_comb begin
        two_w = $signed({w2_reg, 1'b0});
        for (int i = 0; i < LANES; i++) begin
            two_u[i] = $signed({u2_reg[i], 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (e3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e3) begin
            n3_reg <= n2_reg;
            for (int i = 0; i < LANES; i++) begin
                pa3_reg[i] <= vv2_reg[i] * a2_reg;
                pd3_reg[i] <= d2_reg * two_u[i];
                pc3_reg[i] <= c2_reg[i] * two_w;
            end
        end
    end

    // ---------------- stage 4: numerator sum ----------------
    logic signed [NW-1:0] num4_reg [LANES];
    logic [NORM_W-1:0]    n4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (e4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e4) begin
            n4_reg <= n3_reg;
            for (int i = 0; i < LANES; i++) begin
                num4_reg[i] <= NW'(pa3_reg[i]) + NW'(pd3_reg[i]) + NW'(pc3_reg[i]);
            end
        end
    end

    // ---------------- stage 5: sign and magnitude ----------------
    logic [NW-1:0]     mag5_reg [LANES];
    logic [LANES-1:0]  neg5_reg;
    logic [NORM_W-1:0] n5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (e5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e5) begin
            n5_reg <= n4_reg;
            for (int i = 0; i < LANES; i++) begin
                neg5_reg[i] <= num4_reg[i][NW-1];
                mag5_reg[i] <= num4_reg[i][NW-1] ? (~num4_reg[i] + 1'b1) : num4_reg[i];
            end
        end
    end

    // ---------------- divider: stage 0 loads, stages 1..VW take one bit each ----------------
    // A quotient of 2^VW or more saturates, so only the low VW bits are worked out.
    logic                    dv_reg    [0:VW];
    logic [REM_W-1:0]        drem_reg  [0:VW][LANES];
    logic [VW-1:0]           dlq_reg   [0:VW][LANES];
    logic [NORM_W-1:0]       dn_reg    [0:VW];
    logic [LANES-1:0]        dneg_reg  [0:VW];
    logic [LANES-1:0]        dbig_reg  [0:VW];
    logic                    den       [0:VW+1];
    logic                    out_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (den[0]) begin
            dv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (den[0]) begin
            dn_reg[0]   <= n5_reg;
            dneg_reg[0] <= neg5_reg;
            for (int i = 0; i < LANES; i++) begin
                dbig_reg[0][i] <= mag5_reg[i][NW-1:VW] >= HW'(n5_reg);
                drem_reg[0][i] <= mag5_reg[i][VW+REM_W-1:VW];
                dlq_reg[0][i]  <= mag5_reg[i][VW-1:0];
            end
        end
    end

    for (genvar k = 0; k < VW; k++) begin : g_div
        logic [REM_W-1:0] r2   [LANES];
        logic [REM_W-1:0] rnew [LANES];
        logic [LANES-1:0] ge;

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                r2[i]   = {drem_reg[k][i][REM_W-2:0], dlq_reg[k][i][VW-1]};
                ge[i]   = r2[i] >= dn_reg[k];
                rnew[i] = ge[i] ? (r2[i] - dn_reg[k]) : r2[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (den[k+1]) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (den[k+1]) begin
                dn_reg[k+1]   <= dn_reg[k];
                dneg_reg[k+1] <= dneg_reg[k];
                dbig_reg[k+1] <= dbig_reg[k];
                for (int i = 0; i < LANES; i++) begin
                    drem_reg[k+1][i] <= rnew[i];
                    dlq_reg[k+1][i]  <= {dlq_reg[k][i][VW-2:0], ge[i]};
                end
            end
        end
    end

    // ---------------- load enables: a stage moves when empty or its successor moves ----
    for (genvar k = 0; k <= VW; k++) begin : g_en
        assign den[k] = !dv_reg[k] || den[k+1];
    end
    assign den[VW+1] = out_en;
    assign e5        = !v5_reg || den[0];
    assign e4        = !v4_reg || e5;
    assign e3        = !v3_reg || e4;
    assign e2        = !v2_reg || e3;
    assign e1        = !v1_reg || e2;
    assign s_ready   = e1;

    // ---------------- output stage: round half away, saturate ----------------
    logic                 m_valid_reg, zero_reg, sat_reg;
    logic signed [VW-1:0] rot_reg [LANES];
    logic [VW-1:0]        res     [LANES];
    logic [LANES-1:0]     clip;
    logic [VW:0]          qr      [LANES];
    logic                 fin_zero;

    assign out_en   = !m_valid_reg || m_ready;
    assign fin_zero = dn_reg[VW] == '0;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            qr[i] = {1'b0, dlq_reg[VW][i]}
                  + (VW+1)'({drem_reg[VW][i], 1'b0} >= {1'b0, dn_reg[VW]});
            if (fin_zero) begin
                clip[i] = 1'b0;
                res[i]  = '0;
            end else if (!dneg_reg[VW][i]) begin
                clip[i] = dbig_reg[VW][i] || qr[i][VW] || qr[i][VW-1];
                res[i]  = clip[i] ? {1'b0, {(VW-1){1'b1}}} : qr[i][VW-1:0];
            end else begin
                clip[i] = dbig_reg[VW][i] || qr[i][VW]
                       || (qr[i][VW-1] && (|qr[i][VW-2:0]));
                res[i]  = clip[i] ? {1'b1, {(VW-1){1'b0}}} : (~qr[i][VW-1:0] + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= dv_reg[VW];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            zero_reg <= fin_zero;
            sat_reg  <= |clip;
            for (int i = 0; i < LANES; i++) begin
                rot_reg[i] <= $signed(res[i]);
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rot_x     = rot_reg[0];
    assign m_rot_y     = rot_reg[1];
    assign m_rot_z     = rot_reg[2];
    assign m_zero_norm = zero_reg;
    assign m_saturated = sat_reg;

`ifndef SYNTHESIS
    // zero quaternion gives a zero, unclipped word
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_norm |-> m_rot_x == '0 && m_rot_y == '0 && m_rot_z == '0
                                   && !m_saturated)
        else $error("zero norm word carries nonzero data");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a clipped word holds at least one full-scale coordinate
    a_sat_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_rot_x == {1'b0, {(VW-1){1'b1}}} || m_rot_x == {1'b1, {(VW-1){1'b0}}} ||
            m_rot_y == {1'b0, {(VW-1){1'b1}}} || m_rot_y == {1'b1, {(VW-1){1'b0}}} ||
            m_rot_z == {1'b0, {(VW-1){1'b1}}} || m_rot_z == {1'b1, {(VW-1){1'b0}}})
        else $error("saturated flag without a clipped coordinate");
`endif

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for quaternion_vector_rotate (sandwich product q*(0,v)*q^-1).
// Depends on qvr_pkg and the quaternion_vector_rotate RTL; expected words come from an
// in-bench fixed-point rotation computed with wide integers.
module tb_top
    import qvr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = 32;
    localparam int LATENCY = VW + 7;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [VW-1:0] rx, ry, rz;
        logic                 zn, sat;
    } rot_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [QUAT_W-1:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic signed [VW-1:0] s_vec_x = '0, s_vec_y = '0, s_vec_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [VW-1:0] m_rot_x, m_rot_y, m_rot_z;
    logic m_zero_norm, m_saturated;

    rot_word_t expected_rot[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 1'b0;

    quaternion_vector_rotate #(.VEC_WIDTH(VW)) u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Rounded quotient with saturation to the vector range
    function automatic logic signed [VW-1:0] div_round_sat(input logic signed [127:0] num,
            input logic signed [127:0] den, inout logic sat);
        logic [127:0] mag, q, r;
        logic neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        r = mag % den;
        if (2 * r >= den) q = q + 1;
        if (!neg) begin
            if (q > ((128'(1) << (VW-1)) - 128'(1))) begin
                sat = 1'b1;
                return {1'b0, {(VW-1){1'b1}}};
            end
            return q[VW-1:0];
        end
        if (q > (128'(1) << (VW-1))) begin
            sat = 1'b1;
            return {1'b1, {(VW-1){1'b0}}};
        end
        return -q[VW-1:0];
    endfunction

    // Closed-form rotation: ((w^2-u.u)v + 2(u.v)u + 2w(u x v)) / (w^2+u.u)
    function automatic rot_word_t rotate_vec(input logic signed [QUAT_W-1:0] w, x, y, z,
            input logic signed [VW-1:0] vx, vy, vz);
        logic signed [127:0] u[3], v[3], nrm, a, dot, crs[3], num;
        rot_word_t r;
        logic s;
        u[0] = x; u[1] = y; u[2] = z;
        v[0] = vx; v[1] = vy; v[2] = vz;
        nrm = w*w + u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        r = '{default: '0};
        if (nrm == 0) begin
            r.zn = 1'b1;
            return r;
        end
        a = w*w - (u[0]*u[0] + u[1]*u[1] + u[2]*u[2]);
        dot = v[0]*u[0] + v[1]*u[1] + v[2]*u[2];
        crs[0] = u[1]*v[2] - u[2]*v[1];
        crs[1] = u[2]*v[0] - u[0]*v[2];
        crs[2] = u[0]*v[1] - u[1]*v[0];
        s = 1'b0;
        num = a*v[0] + 2*dot*u[0] + 2*w*crs[0];
        r.rx = div_round_sat(num, nrm, s);
        num = a*v[1] + 2*dot*u[1] + 2*w*crs[1];
        r.ry = div_round_sat(num, nrm, s);
        num = a*v[2] + 2*dot*u[2] + 2*w*crs[2];
        r.rz = div_round_sat(num, nrm, s);
        r.sat = s;
        return r;
    endfunction

    // Offer one word, with random idle before it, and wait for acceptance.
    // Valid stays high after acceptance; the next idle cycle or the caller drops it.
    task automatic send_word(input logic signed [QUAT_W-1:0] w, x, y, z,
            input logic signed [VW-1:0] vx, vy, vz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_quat_w <= w; s_quat_x <= x; s_quat_y <= y; s_quat_z <= z;
        s_vec_x <= vx; s_vec_y <= vy; s_vec_z <= vz;
        expected_rot.push_back(rotate_vec(w, x, y, z, vx, vy, vz));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Receiver stall pattern, plus an optional long hold
    always @(posedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        rot_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rot.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = expected_rot.pop_front();
                if (m_rot_x !== e.rx) begin
                    $error("rot_x exp %0d got %0d", e.rx, m_rot_x); errors++;
                end
                if (m_rot_y !== e.ry) begin
                    $error("rot_y exp %0d got %0d", e.ry, m_rot_y); errors++;
                end
                if (m_rot_z !== e.rz) begin
                    $error("rot_z exp %0d got %0d", e.rz, m_rot_z); errors++;
                end
                if (m_zero_norm !== e.zn) begin
                    $error("zero_norm exp %0b got %0b", e.zn, m_zero_norm); errors++;
                end
                if (m_saturated !== e.sat) begin
                    $error("saturated exp %0b got %0b", e.sat, m_saturated); errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [VW-1:0] rand_vec();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed(VW'($urandom_range(2**20))) - (2**19);
            2: return $urandom_range(1) ? {1'b0, {(VW-1){1'b1}}} : {1'b1, {(VW-1){1'b0}}};
            default: return $signed(VW'($urandom_range(2**24))) - (2**23);
        endcase
    endfunction

    function automatic logic signed [QUAT_W-1:0] rand_quat();
        case ($urandom_range(3))
            0: return QUAT_W'($urandom);
            1: return QUAT_W'(int'($urandom_range(32768)) - 16384);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return QUAT_W'(int'($urandom_range(64)) - 32);
        endcase
    endfunction

    task automatic test_extremes();
        send_word(0, 0, 0, 0, 123, -456, 789);
        send_word(0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
        send_word(16384, 0, 0, 0, 32'sh00010000, -32'sh00020000, 32'sh7fffffff);
        send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_word(0, 16384, 0, 0, 32'sh80000000, 32'sh7fffffff, 1);
        send_word(0, 0, 16'sh8000, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_word(11585, 0, 0, 11585, 32'sh7fffffff, 32'sh7fffffff, 0);
        send_word(1, 0, 0, 0, -1, 1, 0);
        send_word(1, 1, 0, 0, 3, 5, -7);
        send_word(3, 0, 1, 0, 1, 1, 1);
        send_word(16'sh7fff, 1, 0, 0, 32'sh80000000, 32'sh80000000, -1);
        send_word(16'shffff, 16'shffff, 16'shffff, 16'shffff, 32'shffffffff, 0, 32'sh55555555);
        send_word(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                  32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_word(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                                 rand_vec(), rand_vec(), rand_vec());
    endtask

    // Receiver holds off while the sender keeps offering, so the pipeline backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (3 * LATENCY) @(posedge aclk);
                recv_hold = 1'b0;
            end
            test_random(2 * LATENCY, 0, 0);
        join
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_random(120, 0, 0);
        test_random(120, 46, 0);
        test_random(120, 0, 46);
        test_random(120, 34, 34);
        test_backpressure();
        s_valid <= 1'b0;
        recv_stall_pct = 20;
        while (expected_rot.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/qvr_pkg.sv
sv/quaternion_vector_rotate.sv
bench/tb_top.sv
